// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gwcr_pkg.sv =====
// Types, constants and dB-to-linear table builder for the gain stage.
package gwcr_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_BITS      = 20;
    localparam int DB_BITS        = 12;
    localparam int LEN_BITS       = 13;
    localparam int SPAN_BITS      = 12;
    localparam int MAX_BLOCK      = 4096;
    localparam int DB_OFFSET      = 1536;
    localparam int DB_TOP         = 384;
    localparam int TABLE_SIZE     = DB_OFFSET + DB_TOP + 1;
    localparam int ROM_ADDR_BITS  = $clog2(TABLE_SIZE);
    localparam int Q56_SHIFT      = 56 - GAIN_FRAC_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [GAIN_BITS-1:0]          gain_t;
    typedef logic signed [DB_BITS-1:0]     db_t;
    typedef logic [LEN_BITS-1:0]           len_t;
    typedef logic [SPAN_BITS-1:0]          span_t;
    typedef logic [ROM_ADDR_BITS-1:0]      rom_addr_t;
    typedef gain_t                         lin_rom_t [TABLE_SIZE];

    localparam db_t  DB_MIN = -db_t'(DB_OFFSET);
    localparam db_t  DB_MAX = db_t'(DB_TOP);
    localparam len_t LEN_MAX = len_t'(MAX_BLOCK);

    localparam logic [63:0] ONE_Q60   = 64'h1000_0000_0000_0000;
    localparam logic [63:0] ONE_Q56   = 64'h0100_0000_0000_0000;
    localparam logic [63:0] UP_HI     = ONE_Q60 + ONE_Q60 / 64'd125;
    localparam logic [63:0] DOWN_LO   = ONE_Q60 - ONE_Q60 / 64'd50;
    localparam logic [63:0] TEN_Q60   = ONE_Q60 * 64'd10;
    localparam logic [63:0] TENTH_Q60 = ONE_Q60 / 64'd10;

    // Q60 multiply, rounded
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        full = {64'd0, a} * {64'd0, b};
        full = full + (128'd1 << 59);
        return full[123:60];
    endfunction

    function automatic logic [63:0] pow320(input logic [63:0] y);
        logic [63:0] s;
        logic [63:0] s64;
        s = y;
        for (int i = 0; i < 6; i++) begin
            s = mul_q60(s, s);
        end
        s64 = s;
        s = mul_q60(s, s);
        s = mul_q60(s, s);
        return mul_q60(s, s64);
    endfunction

    // bisection for the largest y with y^320 <= target
    function automatic logic [63:0] root320(input logic [63:0] lo_in,
                                            input logic [63:0] hi_in,
                                            input logic [63:0] target);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = lo_in;
        hi = hi_in;
        for (int i = 0; i < 62; i++) begin
            mid = lo + ((hi - lo) >> 1);
            if (pow320(mid) <= target) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic gain_t q56_to_gain(input logic [63:0] g);
        logic [63:0] sum;
        logic [63:0] shifted;
        sum = g + (64'd1 << (Q56_SHIFT - 1));
        shifted = sum >> Q56_SHIFT;
        return shifted[GAIN_BITS-1:0];
    endfunction

    function automatic lin_rom_t build_lin_table();
        lin_rom_t    tbl;
        logic [63:0] up;
        logic [63:0] down;
        logic [63:0] g;
        up = root320(ONE_Q60, UP_HI, TEN_Q60);
        down = root320(DOWN_LO, ONE_Q60, TENTH_Q60);
        g = ONE_Q56;
        tbl[DB_OFFSET] = q56_to_gain(g);
        for (int x = 1; x <= DB_TOP; x++) begin
            g = mul_q60(g, up);
            tbl[DB_OFFSET + x] = q56_to_gain(g);
        end
        g = ONE_Q56;
        for (int x = 1; x <= DB_OFFSET; x++) begin
            g = mul_q60(g, down);
            tbl[DB_OFFSET - x] = q56_to_gain(g);
        end
        return tbl;
    endfunction

endpackage

// ===== hw/rtl/gwcr_gain_rom.sv =====
// dB-to-linear gain table, registered read.
module gwcr_gain_rom (
    input  logic                aclk,
    input  gwcr_pkg::rom_addr_t addr,
    output gwcr_pkg::gain_t     data
);

    localparam gwcr_pkg::lin_rom_t LinTable = gwcr_pkg::build_lin_table();

    gwcr_pkg::gain_t data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= LinTable[addr];
    end

    assign data = data_reg;

endmodule

// ===== hw/rtl/gain_with_cubic_ramp.sv =====
// Top level: audio gain stage with cubic gain ramp between block targets.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | sample_in, block_start, target_gain_db, block_len
//  m_      | out | m_valid / m_ready  | sample_out
//
// At constant gain an item passes setup, table load, gain select, output multiply
// and rounding; a ramp item computes the cubic weight and divides instead of gain
// select, the first of a ramp also loading the table and delta. One 24x24 multiplier
// is shared; the division by m^3 is restoring, one quotient bit per cycle.
// Reset (aresetn low, synchronous) returns the gain to unity, 0 dB, no ramp.
// s_ready is high only while idle; an untaken result stalls the next item at rounding.
`include "assert_macros.svh"

module gain_with_cubic_ramp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  gwcr_pkg::sample_t      s_sample_in,
    input  logic                   s_block_start,
    input  gwcr_pkg::db_t          s_target_gain_db,
    input  gwcr_pkg::len_t         s_block_len,
    output logic                   m_valid,
    input  logic                   m_ready,
    output gwcr_pkg::sample_t      m_sample_out
);

    localparam int SampW  = gwcr_pkg::SAMPLE_BITS;
    localparam int GainW  = gwcr_pkg::GAIN_BITS;
    localparam int FracW  = gwcr_pkg::GAIN_FRAC_BITS;
    localparam int SpanW  = gwcr_pkg::SPAN_BITS;
    localparam int MulW   = 24;
    localparam int ProdW  = 2 * MulW;
    localparam int SqW    = 2 * SpanW;
    localparam int CubeW  = 3 * SpanW;
    localparam int CoefW  = SpanW + 2;
    localparam int HalfW  = CubeW / 2;
    localparam int PartW  = GainW + HalfW;
    localparam int NumW   = GainW + CubeW;
    localparam int CntW   = $clog2(GainW);
    localparam int OutPW  = SampW + GainW;
    localparam int RndW   = OutPW + 1;
    localparam int MagW   = RndW - FracW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SETUP, ST_LOAD, ST_DELTA, ST_GAIN, ST_SQ_T, ST_SQ_M, ST_CUBE_M,
        ST_WEIGHT, ST_NUM_LO, ST_NUM_HI, ST_NUM_SUM, ST_DIV, ST_RGAIN, ST_OMUL, ST_ROUND
    } state_t;

    state_t                  state_reg;
    logic                    m_valid_reg;
    gwcr_pkg::sample_t       m_sample_out_reg;

    gwcr_pkg::sample_t       sample_reg;
    logic                    blk_reg;
    gwcr_pkg::db_t           db_in_reg;
    gwcr_pkg::span_t         span_in_reg;

    gwcr_pkg::db_t           prev_gain_db_reg;
    gwcr_pkg::gain_t         ramp_start_gain_reg;
    logic signed [GainW:0]   ramp_delta_reg;
    gwcr_pkg::span_t         sample_index_reg;
    gwcr_pkg::span_t         ramp_span_reg;
    logic                    ramping_reg;

    gwcr_pkg::gain_t         gain_reg;
    logic [ProdW-1:0]        prod_reg;
    logic [SqW-1:0]          t2_reg;
    logic [CubeW-1:0]        m3_reg;
    logic [HalfW-1:0]        w_hi_reg;
    logic [PartW-1:0]        lo_reg;
    logic [CubeW-1:0]        rem_reg;
    logic [GainW-1:0]        div_lo_reg;
    logic [GainW-1:0]        quot_reg;
    logic [CntW-1:0]         cnt_reg;

    gwcr_pkg::db_t           db_sat;
    gwcr_pkg::len_t          len_sat;
    logic [gwcr_pkg::DB_BITS-1:0] idx_sum;
    gwcr_pkg::rom_addr_t     rom_addr;
    gwcr_pkg::gain_t         rom_data;
    logic [MulW-1:0]         mul_a;
    logic [MulW-1:0]         mul_b;
    logic [ProdW-1:0]        mul_p;
    logic [CoefW-1:0]        coef;
    logic [GainW:0]          delta_neg;
    logic [GainW-1:0]        delta_mag;
    logic [NumW-1:0]         num_sum;
    logic [CubeW:0]          div_shift;
    logic [CubeW:0]          div_diff;
    logic                    div_ge;
    logic [CubeW-1:0]        rem_next;
    logic [GainW:0]          ramp_gain_wide;
    gwcr_pkg::sample_t       samp_neg_val;
    logic [SampW-1:0]        samp_mag;
    logic [RndW-1:0]         rnd_sum;
    logic [MagW-1:0]         rmag;
    logic                    pos_ovf;
    logic                    neg_ovf;
    logic [SampW-1:0]        rneg;
    gwcr_pkg::sample_t       round_out;

    always_comb begin
        if (s_target_gain_db < gwcr_pkg::DB_MIN) begin
            db_sat = gwcr_pkg::DB_MIN;
        end else if (s_target_gain_db > gwcr_pkg::DB_MAX) begin
            db_sat = gwcr_pkg::DB_MAX;
        end else begin
            db_sat = s_target_gain_db;
        end
        if (s_block_len == '0) begin
            len_sat = gwcr_pkg::len_t'(1);
        end else if (s_block_len > gwcr_pkg::LEN_MAX) begin
            len_sat = gwcr_pkg::LEN_MAX;
        end else begin
            len_sat = s_block_len;
        end
    end

    // table address always follows the stored target
    assign idx_sum  = prev_gain_db_reg + gwcr_pkg::DB_BITS'(gwcr_pkg::DB_OFFSET);
    assign rom_addr = idx_sum[gwcr_pkg::ROM_ADDR_BITS-1:0];

    gwcr_gain_rom u_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign coef = CoefW'({2'b00, ramp_span_reg} + {1'b0, ramp_span_reg, 1'b0}
                         - {1'b0, sample_index_reg, 1'b0});
    assign delta_neg = -ramp_delta_reg;
    assign delta_mag = ramp_delta_reg[GainW] ? delta_neg[GainW-1:0]
                                             : ramp_delta_reg[GainW-1:0];
    assign samp_neg_val = -sample_reg;
    assign samp_mag = sample_reg[SampW-1] ? samp_neg_val : sample_reg;

    // shared multiplier operand select
    always_comb begin
        case (state_reg)
            ST_SQ_T: begin
                mul_a = MulW'(sample_index_reg);
                mul_b = MulW'(sample_index_reg);
            end
            ST_SQ_M: begin
                mul_a = MulW'(ramp_span_reg);
                mul_b = MulW'(ramp_span_reg);
            end
            ST_CUBE_M: begin
                mul_a = prod_reg[MulW-1:0];
                mul_b = MulW'(ramp_span_reg);
            end
            ST_WEIGHT: begin
                mul_a = MulW'(coef);
                mul_b = MulW'(t2_reg);
            end
            ST_NUM_LO: begin
                mul_a = MulW'(delta_mag);
                mul_b = MulW'(prod_reg[HalfW-1:0]);
            end
            ST_NUM_HI: begin
                mul_a = MulW'(delta_mag);
                mul_b = MulW'(w_hi_reg);
            end
            ST_OMUL, ST_ROUND: begin
                mul_a = samp_mag;
                mul_b = MulW'(gain_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign num_sum   = {prod_reg[PartW-1:0], {HalfW{1'b0}}} + NumW'(lo_reg);
    assign div_shift = {rem_reg, div_lo_reg[GainW-1]};
    assign div_diff  = div_shift - {1'b0, m3_reg};
    assign div_ge    = div_shift >= {1'b0, m3_reg};
    assign rem_next  = div_ge ? div_diff[CubeW-1:0] : div_shift[CubeW-1:0];

    assign ramp_gain_wide = ramp_delta_reg[GainW]
                          ? {1'b0, ramp_start_gain_reg} - {1'b0, quot_reg}
                          : {1'b0, ramp_start_gain_reg} + {1'b0, quot_reg};

    // round half away from zero, then saturate
    assign rnd_sum = RndW'(prod_reg[OutPW-1:0]) + (RndW'(1) << (FracW - 1));
    assign rmag    = rnd_sum[RndW-1:FracW];
    assign pos_ovf = |rmag[MagW-1:SampW-1];
    assign neg_ovf = (|rmag[MagW-1:SampW]) || (rmag[SampW-1] && (|rmag[SampW-2:0]));
    assign rneg    = -rmag[SampW-1:0];

    always_comb begin
        if (sample_reg[SampW-1]) begin
            round_out = neg_ovf ? {1'b1, {(SampW-1){1'b0}}} : rneg;
        end else begin
            round_out = pos_ovf ? {1'b0, {(SampW-1){1'b1}}} : rmag[SampW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_p;
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            m_valid_reg         <= 1'b0;
            prev_gain_db_reg    <= '0;
            ramp_start_gain_reg <= gwcr_pkg::gain_t'(1) << FracW;
            ramp_delta_reg      <= '0;
            sample_index_reg    <= '0;
            ramp_span_reg       <= '0;
            ramping_reg         <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_ROUND)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        sample_reg  <= s_sample_in;
                        blk_reg     <= s_block_start;
                        db_in_reg   <= db_sat;
                        span_in_reg <= SpanW'(len_sat - gwcr_pkg::len_t'(1));
                        state_reg   <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    if (blk_reg && (db_in_reg != prev_gain_db_reg)) begin
                        prev_gain_db_reg <= db_in_reg;
                        if (span_in_reg != '0) begin
                            ramp_start_gain_reg <= rom_data;
                            ramp_span_reg       <= span_in_reg;
                            sample_index_reg    <= '0;
                            ramping_reg         <= 1'b1;
                        end else begin
                            ramping_reg <= 1'b0;
                        end
                        state_reg <= ST_LOAD;
                    end else if (blk_reg) begin
                        ramping_reg <= 1'b0;
                        state_reg   <= ST_LOAD;
                    end else if (ramping_reg) begin
                        state_reg <= ST_SQ_T;
                    end else begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    state_reg <= ramping_reg ? ST_DELTA : ST_GAIN;
                end
                ST_DELTA: begin
                    ramp_delta_reg <= {1'b0, rom_data} - {1'b0, ramp_start_gain_reg};
                    state_reg      <= ST_SQ_T;
                end
                ST_GAIN: begin
                    gain_reg  <= rom_data;
                    state_reg <= ST_OMUL;
                end
                ST_SQ_T: begin
                    state_reg <= ST_SQ_M;
                end
                ST_SQ_M: begin
                    t2_reg    <= prod_reg[SqW-1:0];
                    state_reg <= ST_CUBE_M;
                end
                ST_CUBE_M: begin
                    state_reg <= ST_WEIGHT;
                end
                ST_WEIGHT: begin
                    m3_reg    <= prod_reg[CubeW-1:0];
                    state_reg <= ST_NUM_LO;
                end
                ST_NUM_LO: begin
                    w_hi_reg  <= prod_reg[CubeW-1:HalfW];
                    state_reg <= ST_NUM_HI;
                end
                ST_NUM_HI: begin
                    lo_reg    <= prod_reg[PartW-1:0];
                    state_reg <= ST_NUM_SUM;
                end
                ST_NUM_SUM: begin
                    rem_reg    <= num_sum[NumW-1:GainW];
                    div_lo_reg <= num_sum[GainW-1:0];
                    quot_reg   <= '0;
                    cnt_reg    <= CntW'(GainW - 1);
                    state_reg  <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg    <= rem_next;
                    div_lo_reg <= {div_lo_reg[GainW-2:0], 1'b0};
                    quot_reg   <= {quot_reg[GainW-2:0], div_ge};
                    cnt_reg    <= cnt_reg - CntW'(1);
                    if (cnt_reg == '0) begin
                        state_reg <= ST_RGAIN;
                    end
                end
                ST_RGAIN: begin
                    gain_reg <= ramp_gain_wide[GainW-1:0];
                    if (sample_index_reg >= ramp_span_reg) begin
                        ramping_reg <= 1'b0;
                    end else begin
                        sample_index_reg <= sample_index_reg + gwcr_pkg::span_t'(1);
                    end
                    state_reg <= ST_OMUL;
                end
                ST_OMUL: begin
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    if (!m_valid_reg || m_ready) begin
                        m_sample_out_reg <= round_out;
                        m_valid_reg      <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;

    `ASSERT_IMPL(a_index_in_span, aclk, aresetn, ramping_reg, sample_index_reg <= ramp_span_reg, "ramp index beyond span")
    `ASSERT_IMPL(a_span_nonzero, aclk, aresetn, ramping_reg, ramp_span_reg != '0, "ramp active with zero span")
    `ASSERT_IMPL(a_quot_bound, aclk, aresetn, state_reg == ST_RGAIN, quot_reg <= delta_mag, "ramp step exceeds delta")
    `ASSERT_IMPL(a_out_from_round, aclk, aresetn, $rose(m_valid_reg), $past(state_reg == ST_ROUND), "result not from round stage")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the gain stage with cubic ramp between block targets.
module testbench;
    import gwcr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 600;

    class gain_stage_scoreboard;
        logic [GAIN_BITS-1:0] lin_gain [TABLE_SIZE];
        int          cur_db;
        logic [31:0] ramp_from;
        longint      ramp_diff;
        int unsigned ramp_pos;
        int unsigned ramp_last;
        bit          in_ramp;
        sample_t     gained_samples_due[$];
        int          failures;

        function new();
            build_gain_table();
            cur_db    = 0;
            ramp_from = 32'd1 << GAIN_FRAC_BITS;
            ramp_diff = 0;
            ramp_pos  = 0;
            ramp_last = 0;
            in_ramp   = 1'b0;
            failures  = 0;
        endfunction

        // Q60 product, rounded
        function logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = 128'(a) * 128'(b) + (128'd1 << 59);
            return p[123:60];
        endfunction

        function logic [63:0] pow_320(logic [63:0] y);
            logic [63:0] s;
            logic [63:0] s64;
            s = y;
            repeat (6) s = q60_mul(s, s);
            s64 = s;
            s = q60_mul(s, s);
            s = q60_mul(s, s);
            return q60_mul(s, s64);
        endfunction

        function logic [63:0] root_320(logic [63:0] lo, logic [63:0] hi, logic [63:0] goal);
            logic [63:0] mid;
            repeat (62) begin
                mid = lo + (hi - lo) / 2;
                if (pow_320(mid) <= goal) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
            return lo;
        endfunction

        function logic [GAIN_BITS-1:0] q56_gain(logic [63:0] g);
            logic [63:0] r;
            r = (g + (64'd1 << (55 - GAIN_FRAC_BITS))) >> (56 - GAIN_FRAC_BITS);
            return r[GAIN_BITS-1:0];
        endfunction

        function void build_gain_table();
            logic [63:0] one;
            logic [63:0] up;
            logic [63:0] down;
            logic [63:0] g;
            one  = 64'd1 << 60;
            up   = root_320(one, one + one / 125, one * 10);
            down = root_320(one - one / 50, one, one / 10);
            g = 64'd1 << 56;
            lin_gain[DB_OFFSET] = q56_gain(g);
            for (int x = 1; x <= DB_TOP; x++) begin
                g = q60_mul(g, up);
                lin_gain[DB_OFFSET + x] = q56_gain(g);
            end
            g = 64'd1 << 56;
            for (int x = 1; x <= DB_OFFSET; x++) begin
                g = q60_mul(g, down);
                lin_gain[DB_OFFSET - x] = q56_gain(g);
            end
        endfunction

        // old + delta*(3m-2t)*t^2/m^3, truncated
        function logic [31:0] ramp_gain_now();
            logic [63:0]  m;
            logic [63:0]  t;
            logic [63:0]  w;
            logic [63:0]  m3;
            logic [63:0]  mag;
            logic [127:0] q;
            m   = ramp_last;
            t   = ramp_pos;
            w   = (3 * m - 2 * t) * t * t;
            m3  = m * m * m;
            mag = (ramp_diff < 0) ? -ramp_diff : ramp_diff;
            q   = (128'(mag) * 128'(w)) / 128'(m3);
            return (ramp_diff < 0) ? ramp_from - q[31:0] : ramp_from + q[31:0];
        endfunction

        function void note_input(sample_t smp, logic bs, db_t db, len_t len);
            int          d;
            int unsigned n;
            logic [31:0] gain;
            longint      prod;
            longint      mag;
            longint      r;
            longint      val;
            if (bs) begin
                d = db;
                if (d < -DB_OFFSET) d = -DB_OFFSET;
                if (d > DB_TOP) d = DB_TOP;
                n = len;
                if (n == 0) n = 1;
                if (n > MAX_BLOCK) n = MAX_BLOCK;
                if (d != cur_db) begin
                    if (n >= 2) begin
                        ramp_from = lin_gain[cur_db + DB_OFFSET];
                        ramp_diff = longint'(lin_gain[d + DB_OFFSET]) - longint'(ramp_from);
                        ramp_last = n - 1;
                        ramp_pos  = 0;
                        in_ramp   = 1'b1;
                    end else begin
                        in_ramp = 1'b0;
                    end
                    cur_db = d;
                end else begin
                    in_ramp = 1'b0;
                end
            end
            if (in_ramp) begin
                gain = ramp_gain_now();
                if (ramp_pos >= ramp_last) begin
                    in_ramp = 1'b0;
                end else begin
                    ramp_pos++;
                end
            end else begin
                gain = lin_gain[cur_db + DB_OFFSET];
            end
            prod = longint'(smp) * longint'(gain);
            mag  = (prod < 0) ? -prod : prod;
            r    = (mag + (longint'(1) << (GAIN_FRAC_BITS - 1))) >> GAIN_FRAC_BITS;
            val  = (prod < 0) ? -r : r;
            if (val > 8388607) val = 8388607;
            if (val < -8388608) val = -8388608;
            gained_samples_due.push_back(sample_t'(val));
        endfunction

        function void check_output(sample_t got);
            sample_t want;
            if (gained_samples_due.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected item on m_: sample_out %0d", got);
                return;
            end
            want = gained_samples_due.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: sample_out expected %0d got %0d", want, got);
                end
            end
        endfunction

        function int pending();
            return gained_samples_due.size();
        endfunction

        function void finish_check();
            if (gained_samples_due.size() != 0) begin
                failures++;
                $display("%0d expected items never arrived", gained_samples_due.size());
            end
        endfunction
    endclass

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    sample_t s_sample_in = '0;
    logic    s_block_start = 1'b0;
    db_t     s_target_gain_db = '0;
    len_t    s_block_len = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    sample_t m_sample_out;

    gain_stage_scoreboard gains = new();

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   outputs_seen = 0;
    int   hold_left = 0;
    bit   held_once = 1'b0;
    int   cycles = 0;
    int   items_sent;
    db_t  last_db = '0;

    gain_with_cubic_ramp u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample_in      (s_sample_in),
        .s_block_start    (s_block_start),
        .s_target_gain_db (s_target_gain_db),
        .s_block_len      (s_block_len),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sample_out     (m_sample_out)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result check and receiver stalls; one long hold-off fills the block
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            gains.check_output(m_sample_out);
            outputs_seen++;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!held_once && outputs_seen >= 1500) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(sample_t smp, logic bs, db_t db, len_t len);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_sample_in      <= smp;
        s_block_start    <= bs;
        s_target_gain_db <= db;
        s_block_len      <= len;
        do @(posedge aclk); while (!s_ready);
        gains.note_input(smp, bs, db, len);
    endtask

    function automatic sample_t rand_sample();
        int pick;
        int tie;
        pick = $urandom_range(99);
        if (pick < 70) return sample_t'($urandom());
        if (pick < 85) return sample_t'(int'($urandom_range(200000)) - 100000);
        if (pick < 92) return ($urandom_range(1) != 0) ? sample_t'(8388607) : sample_t'(-8388608);
        // half-LSB products for odd gains
        tie = 32768 * (2 * int'($urandom_range(127)) + 1);
        return ($urandom_range(1) != 0) ? sample_t'(tie) : sample_t'(-tie);
    endfunction

    task automatic random_block();
        db_t  db;
        len_t len;
        int   pick;
        int   n;
        pick = $urandom_range(99);
        if (pick < 12) begin
            db = last_db;
        end else if (pick < 25) begin
            db = db_t'($urandom());
        end else begin
            db = db_t'(int'($urandom_range(DB_OFFSET + DB_TOP)) - DB_OFFSET);
        end
        pick = $urandom_range(99);
        if (pick < 65) begin
            len = len_t'($urandom_range(12, 1));
        end else if (pick < 88) begin
            len = len_t'($urandom_range(80, 13));
        end else begin
            len = len_t'($urandom());
        end
        n = (len == 0) ? 1 : ((len > MAX_BLOCK) ? MAX_BLOCK : int'(len));
        pick = $urandom_range(99);
        if (pick < 8 && n > 1) begin
            n = $urandom_range(n - 1, 1);
        end else if (pick < 16) begin
            n = n + $urandom_range(5, 1);
        end
        if (n > 90) n = $urandom_range(90, 20);
        last_db = db;
        send_item(rand_sample(), 1'b1, db, len);
        for (int i = 1; i < n; i++) begin
            send_item(rand_sample(), 1'b0, db_t'($urandom()), len_t'($urandom()));
        end
        items_sent += n;
    endtask

    task automatic random_phase(int count);
        items_sent = 0;
        while (items_sent < count) random_block();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 37;
        recv_idle_pct = 74;

        // unity gain, sample extremes
        send_item(sample_t'(8388607), 1'b1, db_t'(0), len_t'(1));
        send_item(sample_t'(-8388608), 1'b0, db_t'(0), len_t'(1));
        // jump to top gain, saturation both ways
        send_item(sample_t'(8388607), 1'b1, db_t'(384), len_t'(1));
        send_item(sample_t'(-8388608), 1'b0, db_t'(0), len_t'(0));
        send_item(sample_t'(1), 1'b0, db_t'(0), len_t'(0));
        // out-of-range target clamps to the same value, long length clamps
        send_item(sample_t'(-1), 1'b1, db_t'(2047), len_t'(8191));
        // bottom clamp with zero length: jump, rounding ties
        send_item(sample_t'(32768), 1'b1, db_t'(-2048), len_t'(0));
        send_item(sample_t'(-32768), 1'b0, db_t'(0), len_t'(0));
        send_item(sample_t'(98304), 1'b1, db_t'(-1536), len_t'(5));
        // ramp up over six samples, then two past the block end
        send_item(sample_t'(8388607), 1'b1, db_t'(0), len_t'(6));
        for (int i = 0; i < 7; i++) begin
            send_item(sample_t'(4000000 - 1000000 * i), 1'b0, db_t'(-1), len_t'(4096));
        end
        send_item(sample_t'(7777777), 1'b1, db_t'(-1), len_t'(2));
        send_item(sample_t'(-7777777), 1'b0, db_t'(0), len_t'(0));
        // long ramp cut short by a new block
        send_item(sample_t'(5000000), 1'b1, db_t'(384), len_t'(4096));
        send_item(sample_t'(-5000000), 1'b0, db_t'(0), len_t'(0));
        send_item(sample_t'(123457), 1'b0, db_t'(0), len_t'(0));
        send_item(sample_t'(2000000), 1'b1, db_t'(-768), len_t'(3));
        send_item(sample_t'(-2000000), 1'b0, db_t'(0), len_t'(0));
        send_item(sample_t'(2000000), 1'b0, db_t'(0), len_t'(0));
        last_db = db_t'(-768);

        random_phase(630);
        send_idle_pct = 74;
        recv_idle_pct = 37;
        random_phase(630);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(630);

        s_valid <= 1'b0;
        while (gains.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        gains.finish_check();
        if (gains.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/gwcr_pkg.sv
hw/rtl/gwcr_gain_rom.sv
hw/rtl/gain_with_cubic_ramp.sv
tb/testbench.sv
